// File: rtl/core/dfn_pkg.sv
// Package of the directional focus navigator: sizes, codes, payload and internal types.
`default_nettype none

package dfn_pkg;

    localparam int ENTRIES  = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int COORD_W  = 12;
    localparam int CENTRE_W = COORD_W + 1;
    localparam int ROW_W    = 8;
    localparam int SCORE_W  = CENTRE_W + 3;

    // Command codes.
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_FOCUS  = 3'd2;
    localparam logic [2:0] CMD_BLUR   = 3'd3;
    localparam logic [2:0] CMD_NAV    = 3'd4;
    localparam logic [2:0] CMD_UPDATE = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX    = 2'd1;
    localparam logic [1:0] STATUS_FULL         = 2'd2;
    localparam logic [1:0] STATUS_NO_NEIGHBOUR = 2'd3;

    // Direction codes.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CUR,
        ST_SCAN,
        ST_NAV_DONE
    } dfn_state_t;

    typedef struct packed {
        logic [2:0]                cmd;
        logic [IDX_W-1:0]          entry_index;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0]        rect_w;
        logic [COORD_W-1:0]        rect_h;
        logic [ROW_W-1:0]          row_number;
        logic [1:0]                direction;
    } dfn_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_index;
        logic             blur_event;
        logic [IDX_W-1:0] blurred_index;
        logic             focus_event;
        logic             focused_valid;
        logic [IDX_W-1:0] focused_index;
        logic [CNT_W-1:0] entry_count;
    } dfn_result_t;

    typedef struct packed {
        logic [CENTRE_W-1:0] x;
        logic [CENTRE_W-1:0] y;
    } dfn_centre_t;

    // Set-up of one navigation scan, fixed for its whole length.
    typedef struct packed {
        logic [1:0]       dir;
        logic             row_limited;
        logic [IDX_W-1:0] cur_idx;
        dfn_centre_t      cur_centre;
        logic [ROW_W-1:0] cur_row;
    } dfn_scan_cfg_t;

    // One entry read back from the table during a scan.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        dfn_centre_t      centre;
        logic [ROW_W-1:0] row;
    } dfn_scan_rd_t;

    typedef struct packed {
        logic             busy;
        logic             found;
        logic [IDX_W-1:0] lead_idx;
    } dfn_scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/directional_focus_navigator.sv
// Top level of the directional focus navigator: command sequencer, entry table and result register.
`default_nettype none

// Channel   Signals                                  Width        Transfer when
// item      item_valid, item_ready, item             dfn_item_t   item_valid && item_ready
// result    result_valid, result_ready, result       dfn_result_t result_valid && result_ready
// cfg       cfg_valid, cfg_ready, cfg_data           1 bit        cfg_valid && cfg_ready
//
// Add, clear, focus, blur and update commands are carried out in the execute state, which
// writes the result register and returns to idle, where the next item can transfer.
// A navigate command walks the whole table through the single read port of the entry
// memory, one entry per cycle: the execute state reads the focused entry, the scan states
// issue the reads and drain the scoring pipeline, and the done state writes the result.
// Reset clears the entry count, the focus and the mode; the table memories are not
// cleared, since only entries below the count are ever used.
// One command is in progress at a time; a new item is taken while the previous result
// still waits in the output register, and a stalled result only holds the sequencer at
// the point where the next result would be written.

module directional_focus_navigator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  dfn_pkg::dfn_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output dfn_pkg::dfn_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import dfn_pkg::*;

    // The table: centres in one memory and rows in another, so that an update of the
    // rectangle rewrites the centre without a read of the row.
    dfn_centre_t      pos_mem [ENTRIES];
    logic [ROW_W-1:0] row_mem [ENTRIES];

    dfn_state_t       state_reg;
    dfn_state_t       state_next;
    dfn_item_t        item_reg;
    logic             nav_mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             focus_valid_reg;
    logic             focus_valid_next;
    logic [IDX_W-1:0] focus_index_reg;
    logic [IDX_W-1:0] focus_index_next;
    dfn_result_t      result_reg;
    dfn_result_t      result_next;
    logic             result_valid_reg;
    logic             result_valid_next;

    // Scan address counter and the read that is in flight.
    logic [CNT_W-1:0] iss_reg;
    logic [CNT_W-1:0] iss_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;
    dfn_scan_cfg_t    scan_cfg_reg;
    dfn_scan_cfg_t    scan_cfg_next;

    dfn_centre_t      pos_rd_reg;
    logic [ROW_W-1:0] row_rd_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             pos_we;
    logic             row_we;
    dfn_centre_t      item_centre;

    logic             slot_free;
    logic             focus_ok;
    logic             idx_ok;
    logic             scan_start;
    logic             do_finish;
    logic             do_focus;
    logic [IDX_W-1:0] target;
    logic [1:0]       status;
    logic [IDX_W-1:0] res_idx;
    logic             blur_ev;
    logic [IDX_W-1:0] blurred;

    dfn_scan_rd_t     scan_rd;
    dfn_scan_res_t    scan_res;

    // The centre is the left or top edge plus half the size, rounded down; it needs one
    // more bit than the edge.
    always_comb
    begin
        item_centre.x = {item_reg.rect_x[COORD_W-1], item_reg.rect_x}
                      + {2'b00, item_reg.rect_w[COORD_W-1:1]};
        item_centre.y = {item_reg.rect_y[COORD_W-1], item_reg.rect_y}
                      + {2'b00, item_reg.rect_h[COORD_W-1:1]};
    end

    assign focus_ok  = focus_valid_reg && ({1'b0, focus_index_reg} < count_reg);
    assign idx_ok    = {1'b0, item_reg.entry_index} < count_reg;
    assign slot_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        focus_valid_next  = focus_valid_reg;
        focus_index_next  = focus_index_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        iss_next          = iss_reg;
        rd_valid_next     = 1'b0;
        rd_idx_next       = rd_idx_reg;
        scan_cfg_next     = scan_cfg_reg;
        scan_start        = 1'b0;
        rd_addr           = iss_reg[IDX_W-1:0];
        wr_addr           = count_reg[IDX_W-1:0];
        pos_we            = 1'b0;
        row_we            = 1'b0;
        item_ready        = 1'b0;
        do_finish         = 1'b0;
        do_focus          = 1'b0;
        target            = '0;
        status            = STATUS_OK;
        res_idx           = '0;
        blur_ev           = 1'b0;
        blurred           = '0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Read the focused entry in case this is a navigate command.
                rd_addr = focus_index_reg;
                if ((item_reg.cmd == CMD_NAV) && focus_ok)
                begin
                    scan_start                = 1'b1;
                    scan_cfg_next.dir         = item_reg.direction;
                    scan_cfg_next.row_limited = nav_mode_reg ^ ~item_reg.direction[1];
                    scan_cfg_next.cur_idx     = focus_index_reg;
                    iss_next                  = '0;
                    state_next                = ST_CUR;
                end
                else if (slot_free)
                begin
                    do_finish  = 1'b1;
                    state_next = ST_IDLE;
                    unique case (item_reg.cmd)
                        CMD_ADD:
                        begin
                            if (count_reg >= CNT_W'(ENTRIES))
                            begin
                                status = STATUS_FULL;
                            end
                            else
                            begin
                                pos_we     = 1'b1;
                                row_we     = 1'b1;
                                res_idx    = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next       = '0;
                            focus_valid_next = 1'b0;
                            focus_index_next = '0;
                        end
                        CMD_FOCUS:
                        begin
                            if (idx_ok)
                            begin
                                do_focus = 1'b1;
                                target   = item_reg.entry_index;
                            end
                            else
                            begin
                                status = STATUS_BAD_INDEX;
                            end
                        end
                        CMD_BLUR:
                        begin
                            if (focus_valid_reg)
                            begin
                                blur_ev          = 1'b1;
                                blurred          = focus_index_reg;
                                focus_valid_next = 1'b0;
                                focus_index_next = '0;
                            end
                        end
                        CMD_NAV:
                        begin
                            // Navigation with no valid focus.
                            status = STATUS_BAD_INDEX;
                        end
                        CMD_UPDATE:
                        begin
                            wr_addr = item_reg.entry_index;
                            if (idx_ok)
                            begin
                                pos_we = 1'b1;
                            end
                            else
                            begin
                                status = STATUS_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CUR:
            begin
                // The focused entry's data is here now; the scan reads start alongside.
                scan_cfg_next.cur_centre = pos_rd_reg;
                scan_cfg_next.cur_row    = row_rd_reg;
                state_next               = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((iss_reg == count_reg) && !rd_valid_reg && !scan_res.busy)
                begin
                    state_next = ST_NAV_DONE;
                end
            end
            ST_NAV_DONE:
            begin
                if (slot_free)
                begin
                    do_finish  = 1'b1;
                    state_next = ST_IDLE;
                    if (scan_res.found)
                    begin
                        do_focus = 1'b1;
                        target   = scan_res.lead_idx;
                    end
                    else
                    begin
                        status = STATUS_NO_NEIGHBOUR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Issue one table read per cycle until every entry below the count is out.
        if (((state_reg == ST_CUR) || (state_reg == ST_SCAN)) && (iss_reg < count_reg))
        begin
            rd_valid_next = 1'b1;
            rd_idx_next   = iss_reg[IDX_W-1:0];
            iss_next      = iss_reg + CNT_W'(1);
        end

        // Moving focus blurs the old entry, even when it is the same one.
        if (do_focus)
        begin
            if (focus_ok)
            begin
                blur_ev = 1'b1;
                blurred = focus_index_reg;
            end
            focus_valid_next = 1'b1;
            focus_index_next = target;
            res_idx          = target;
        end

        if (do_finish)
        begin
            result_valid_next          = 1'b1;
            result_next.status         = status;
            result_next.result_index   = res_idx;
            result_next.blur_event     = blur_ev;
            result_next.blurred_index  = blurred;
            result_next.focus_event    = do_focus;
            result_next.focused_valid  = focus_valid_next;
            result_next.focused_index  = focus_valid_next ? focus_index_next : '0;
            result_next.entry_count    = count_next;
        end
    end

    // Writes happen only in the execute state, and the read data is used only during a
    // navigate command, which writes nothing, so a read that meets a write is never used.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[wr_addr] <= item_centre;
        end
        if (row_we)
        begin
            row_mem[wr_addr] <= item_reg.row_number;
        end
        pos_rd_reg <= pos_mem[rd_addr];
        row_rd_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            nav_mode_reg     <= 1'b0;
            count_reg        <= '0;
            focus_valid_reg  <= 1'b0;
            focus_index_reg  <= '0;
            result_valid_reg <= 1'b0;
            iss_reg          <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            focus_valid_reg  <= focus_valid_next;
            focus_index_reg  <= focus_index_next;
            result_valid_reg <= result_valid_next;
            iss_reg          <= iss_next;
            rd_valid_reg     <= rd_valid_next;
            if (cfg_valid)
            begin
                nav_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        result_reg   <= result_next;
        rd_idx_reg   <= rd_idx_next;
        scan_cfg_reg <= scan_cfg_next;
    end

    assign scan_rd.valid  = rd_valid_reg;
    assign scan_rd.idx    = rd_idx_reg;
    assign scan_rd.centre = pos_rd_reg;
    assign scan_rd.row    = row_rd_reg;

    dfn_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .cfg   (scan_cfg_reg),
        .rd    (scan_rd),
        .res   (scan_res)
    );

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/dfn_scan.sv
// Scoring pipeline of the navigation scan: candidate test, score and running best.
`default_nettype none

module dfn_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  dfn_pkg::dfn_scan_cfg_t cfg,
    input  dfn_pkg::dfn_scan_rd_t  rd,
    output dfn_pkg::dfn_scan_res_t res
);
    import dfn_pkg::*;

    logic [CENTRE_W:0]   dx_s;
    logic [CENTRE_W:0]   dy_s;
    logic [CENTRE_W:0]   dx_abs;
    logic [CENTRE_W:0]   dy_abs;
    logic [CENTRE_W-1:0] prim;
    logic [CENTRE_W-1:0] lat;
    logic                vertical;
    logic                ahead;
    logic                cand;
    logic [SCORE_W-1:0]  score;

    logic               b_valid_reg;
    logic               b_cand_reg;
    logic [SCORE_W-1:0] b_score_reg;
    logic [IDX_W-1:0]   b_idx_reg;

    logic               found_reg;
    logic               found_next;
    logic [SCORE_W-1:0] best_score_reg;
    logic [SCORE_W-1:0] best_score_next;
    logic [IDX_W-1:0]   lead_idx_reg;
    logic [IDX_W-1:0]   lead_idx_next;

    // Differences are taken one bit wider so that their sign is exact.
    always_comb
    begin
        dx_s = {rd.centre.x[CENTRE_W-1], rd.centre.x}
             - {cfg.cur_centre.x[CENTRE_W-1], cfg.cur_centre.x};
        dy_s = {rd.centre.y[CENTRE_W-1], rd.centre.y}
             - {cfg.cur_centre.y[CENTRE_W-1], cfg.cur_centre.y};
        dx_abs = dx_s[CENTRE_W] ? (~dx_s + 1'b1) : dx_s;
        dy_abs = dy_s[CENTRE_W] ? (~dy_s + 1'b1) : dy_s;
        vertical = ~cfg.dir[1];
        unique case (cfg.dir)
            DIR_UP:    ahead = dy_s[CENTRE_W];
            DIR_DOWN:  ahead = ~dy_s[CENTRE_W] && (dy_s != '0);
            DIR_LEFT:  ahead = dx_s[CENTRE_W];
            DIR_RIGHT: ahead = ~dx_s[CENTRE_W] && (dx_s != '0);
            default:   ahead = 1'b0;
        endcase
        prim  = vertical ? dy_abs[CENTRE_W-1:0] : dx_abs[CENTRE_W-1:0];
        lat   = vertical ? dx_abs[CENTRE_W-1:0] : dy_abs[CENTRE_W-1:0];
        score = SCORE_W'({prim, 1'b0}) + SCORE_W'({lat, 1'b0}) + SCORE_W'(lat);
        cand  = (rd.idx != cfg.cur_idx) && ahead
             && (!cfg.row_limited || (rd.row == cfg.cur_row));
    end

    // Entries arrive in ascending order, so a strict compare keeps the lowest index on ties.
    always_comb
    begin
        found_next      = found_reg;
        best_score_next = best_score_reg;
        lead_idx_next   = lead_idx_reg;
        if (start)
        begin
            found_next = 1'b0;
        end
        else if (b_valid_reg && b_cand_reg && (!found_reg || (b_score_reg < best_score_reg)))
        begin
            found_next      = 1'b1;
            best_score_next = b_score_reg;
            lead_idx_next   = b_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            b_valid_reg <= rd.valid;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_cand_reg     <= cand;
        b_score_reg    <= score;
        b_idx_reg      <= rd.idx;
        best_score_reg <= best_score_next;
        lead_idx_reg   <= lead_idx_next;
    end

    assign res.busy     = b_valid_reg;
    assign res.found    = found_reg;
    assign res.lead_idx = lead_idx_reg;

endmodule

`default_nettype wire

// File: rtl/core/dfn_checker.sv
// Port checker of the directional focus navigator and its bind to the top level.
`default_nettype none

module dfn_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire dfn_pkg::dfn_result_t result
);
    import dfn_pkg::*;

    // A stalled result transfer keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A gained focus is the reported entry and is the focus afterwards.
    a_focus_event: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.focus_event |->
            result.focused_valid && (result.focused_index == result.result_index)
            && (result.status == STATUS_OK))
        else $error("focus event inconsistent with focus state");

    // A failed command neither focuses nor reports an index.
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_OK) |->
            !result.focus_event && (result.result_index == '0))
        else $error("failed command reported a focus or an index");

    // The focused entry always lies inside the table, and an unfocused index reads zero.
    a_focus_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.focused_valid && ({1'b0, result.focused_index} < result.entry_count))
            || (!result.focused_valid && (result.focused_index == '0)))
        else $error("focused index outside the table");

endmodule

bind directional_focus_navigator dfn_checker u_dfn_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench of the directional focus navigator, with its own model of the entry table.
`timescale 1ns / 100ps

module tb_top;

    import dfn_pkg::*;

    // Commands 6 and 7 have no meaning; the block must ignore them and still answer.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int          ITEM_TARGET   = 1700;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 80;
    localparam int          HOLD_AFTER    = 500;
    localparam int          HOLD_CYCLES   = 300;
    localparam longint      CYCLE_LIMIT   = 1000000;
    localparam dfn_result_t NO_OUTCOME    = '0;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    dfn_item_t   item;
    logic        result_valid;
    logic        result_ready;
    dfn_result_t result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    directional_focus_navigator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // The testbench's own picture of the block: the centres and rows of the table, the entry
    // count, the focus and the navigation mode. Centres are held as plain integers; they
    // never leave the 13-bit signed range, and scores stay well inside 16 bits.
    int tab_cx [ENTRIES];
    int tab_cy [ENTRIES];
    int tab_row [ENTRIES];
    int table_count;
    bit focus_held;
    int focus_at;
    bit mode_now;

    // Outcomes still owed by the block, oldest first.
    dfn_result_t pending_outcomes [$];

    int     items_accepted;
    int     mismatches;
    int     send_calm;
    int     recv_calm;
    bit     long_hold_done;
    longint cycle_count;
    int     phase_count;

    // One row of the directed script. Where the outcome is obvious it is typed in here;
    // everywhere else the model supplies it.
    typedef struct {
        dfn_item_t   stim;
        bit          typed;
        dfn_result_t want;
    } script_row_t;

    script_row_t script [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out what one accepted command must produce, and moves the model on by one step.
    function automatic dfn_result_t compute_focus_outcome(input dfn_item_t s);
        dfn_result_t o;
        int          cx;
        int          cy;
        int          ux;
        int          uy;
        int          dp;
        int          dl;
        int          score;
        int          best;
        int          target;
        bit          take_focus;
        bit          found;
        bit          vertical;
        bit          row_limited;
        bit          ahead;
        o = '0;
        cx = $signed(s.rect_x);
        cx = cx + int'(s.rect_w >> 1);
        cy = $signed(s.rect_y);
        cy = cy + int'(s.rect_h >> 1);
        target = 0;
        take_focus = 1'b0;
        case (s.cmd)
            CMD_ADD:
            begin
                if (table_count >= ENTRIES)
                begin
                    o.status = STATUS_FULL;
                end
                else
                begin
                    tab_cx[table_count] = cx;
                    tab_cy[table_count] = cy;
                    tab_row[table_count] = int'(s.row_number);
                    o.result_index = IDX_W'(table_count);
                    table_count++;
                end
            end
            CMD_CLEAR:
            begin
                table_count = 0;
                focus_held = 1'b0;
                focus_at = 0;
            end
            CMD_FOCUS:
            begin
                if (int'(s.entry_index) >= table_count)
                begin
                    o.status = STATUS_BAD_INDEX;
                end
                else
                begin
                    target = int'(s.entry_index);
                    take_focus = 1'b1;
                end
            end
            CMD_BLUR:
            begin
                if (focus_held)
                begin
                    o.blur_event = 1'b1;
                    o.blurred_index = IDX_W'(focus_at);
                    focus_held = 1'b0;
                    focus_at = 0;
                end
            end
            CMD_NAV:
            begin
                if (!focus_held || focus_at >= table_count)
                begin
                    o.status = STATUS_BAD_INDEX;
                end
                else
                begin
                    ux = tab_cx[focus_at];
                    uy = tab_cy[focus_at];
                    vertical = (s.direction == DIR_UP) || (s.direction == DIR_DOWN);
                    // Player mode fences up and down within a row, host mode left and right.
                    row_limited = (mode_now == 1'b0) == vertical;
                    found = 1'b0;
                    best = 0;
                    for (int i = 0; i < table_count; i++)
                    begin
                        if (i == focus_at)
                            continue;
                        if (row_limited && tab_row[i] != tab_row[focus_at])
                            continue;
                        case (s.direction)
                            DIR_UP:   ahead = tab_cy[i] < uy;
                            DIR_DOWN: ahead = tab_cy[i] > uy;
                            DIR_LEFT: ahead = tab_cx[i] < ux;
                            default:  ahead = tab_cx[i] > ux;
                        endcase
                        if (!ahead)
                            continue;
                        dp = vertical ? tab_cy[i] - uy : tab_cx[i] - ux;
                        dl = vertical ? tab_cx[i] - ux : tab_cy[i] - uy;
                        if (dp < 0)
                            dp = -dp;
                        if (dl < 0)
                            dl = -dl;
                        score = 2 * dp + 3 * dl;
                        // Strictly lower only, so the lowest index keeps a tie.
                        if (!found || score < best)
                        begin
                            found = 1'b1;
                            best = score;
                            target = i;
                        end
                    end
                    if (found)
                        take_focus = 1'b1;
                    else
                        o.status = STATUS_NO_NEIGHBOUR;
                end
            end
            CMD_UPDATE:
            begin
                if (int'(s.entry_index) >= table_count)
                begin
                    o.status = STATUS_BAD_INDEX;
                end
                else
                begin
                    tab_cx[s.entry_index] = cx;
                    tab_cy[s.entry_index] = cy;
                end
            end
            default:
            begin
            end
        endcase
        // Gaining focus always blurs the previous holder, even when it is the same entry.
        if (take_focus)
        begin
            if (focus_held && focus_at < table_count)
            begin
                o.blur_event = 1'b1;
                o.blurred_index = IDX_W'(focus_at);
            end
            focus_held = 1'b1;
            focus_at = target;
            o.focus_event = 1'b1;
            o.result_index = IDX_W'(target);
        end
        o.focused_valid = focus_held;
        o.focused_index = focus_held ? IDX_W'(focus_at) : '0;
        o.entry_count = CNT_W'(table_count);
        return o;
    endfunction

    function automatic dfn_item_t make_item(input logic [2:0] op, input int idx, input int x,
                                            input int y, input int w, input int h,
                                            input int row, input logic [1:0] dir);
        dfn_item_t s;
        s.cmd = op;
        s.entry_index = IDX_W'(idx);
        s.rect_x = COORD_W'(x);
        s.rect_y = COORD_W'(y);
        s.rect_w = COORD_W'(w);
        s.rect_h = COORD_W'(h);
        s.row_number = ROW_W'(row);
        s.direction = dir;
        return s;
    endfunction

    function automatic dfn_result_t make_outcome(input logic [1:0] st, input int res,
                                                 input bit be, input int bi, input bit fe,
                                                 input bit fv, input int fi, input int cnt);
        dfn_result_t o;
        o.status = st;
        o.result_index = IDX_W'(res);
        o.blur_event = be;
        o.blurred_index = IDX_W'(bi);
        o.focus_event = fe;
        o.focused_valid = fv;
        o.focused_index = IDX_W'(fi);
        o.entry_count = CNT_W'(cnt);
        return o;
    endfunction

    function automatic void add_row(input dfn_item_t s, input bit typed, input dfn_result_t w);
        script_row_t r;
        r.stim = s;
        r.typed = typed;
        r.want = w;
        script.push_back(r);
    endfunction

    // A command with every field random, then shaped to the given operation. Gridded items
    // sit on a coarse lattice in a handful of rows, which gives many candidates and ties;
    // the others spread over the whole coordinate range.
    function automatic dfn_item_t shaped_item(input logic [2:0] op, input bit gridded);
        logic [95:0] raw;
        dfn_item_t   s;
        raw = {$urandom, $urandom, $urandom};
        s = raw[$bits(dfn_item_t)-1:0];
        s.cmd = op;
        if (gridded)
        begin
            s.rect_x = COORD_W'(int'($urandom_range(0, 8)) * 96 - 384);
            s.rect_y = COORD_W'(int'($urandom_range(0, 8)) * 96 - 384);
            s.rect_w = COORD_W'($urandom_range(0, 2) * 16);
            s.rect_h = COORD_W'($urandom_range(0, 2) * 16);
            s.row_number = ROW_W'($urandom_range(0, 2));
        end
        // Focus and update mostly aim at an existing entry.
        if (table_count > 0 && $urandom_range(0, 4) != 0)
            s.entry_index = IDX_W'($urandom_range(0, table_count - 1));
        return s;
    endfunction

    // Either side draws a random wait per transfer, apart from calm stretches with no wait.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one command and holds it until the transfer; the outcome is booked at that edge.
    // When no gap is drawn, valid stays high straight into the next command.
    task automatic offer_command(input dfn_item_t s, input bit typed, input dfn_result_t w);
        int          gap;
        dfn_result_t predicted;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= s;
        do @(posedge clk); while (!item_ready);
        predicted = compute_focus_outcome(s);
        pending_outcomes.push_back(typed ? w : predicted);
        items_accepted++;
    endtask

    // Stops offering and waits until every outcome has been delivered, plus a short pause.
    task automatic settle(input int pause);
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    task automatic program_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_now = mode;
    endtask

    // One phase: perhaps a clear, a run of adds (now and then past a full table), a focus,
    // and then a mix that leans on navigation, with some malformed commands thrown in.
    task automatic run_phase(input bit gridded);
        int        adds;
        int        ops;
        int        pick;
        dfn_item_t s;
        if ($urandom_range(0, 2) == 0)
            offer_command(shaped_item(CMD_CLEAR, gridded), 1'b0, NO_OUTCOME);
        adds = ($urandom_range(0, 11) == 0) ? ENTRIES + 2 : $urandom_range(1, 10);
        repeat (adds) offer_command(shaped_item(CMD_ADD, gridded), 1'b0, NO_OUTCOME);
        offer_command(shaped_item(CMD_FOCUS, gridded), 1'b0, NO_OUTCOME);
        ops = $urandom_range(10, 40);
        repeat (ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if (!focus_held && table_count > 0 && $urandom_range(0, 9) < 7)
                    offer_command(shaped_item(CMD_FOCUS, gridded), 1'b0, NO_OUTCOME);
                offer_command(shaped_item(CMD_NAV, gridded), 1'b0, NO_OUTCOME);
            end
            else if (pick < 60)
                offer_command(shaped_item(CMD_FOCUS, gridded), 1'b0, NO_OUTCOME);
            else if (pick < 70)
                offer_command(shaped_item(CMD_UPDATE, gridded), 1'b0, NO_OUTCOME);
            else if (pick < 77)
                offer_command(shaped_item(CMD_ADD, gridded), 1'b0, NO_OUTCOME);
            else if (pick < 83)
                offer_command(shaped_item(CMD_BLUR, gridded), 1'b0, NO_OUTCOME);
            else if (pick < 86)
                offer_command(shaped_item(CMD_CLEAR, gridded), 1'b0, NO_OUTCOME);
            else
            begin
                // Any command at all, with every field left random.
                s = shaped_item(CMD_ADD, 1'b0);
                s.cmd = 3'($urandom_range(0, 7));
                offer_command(s, 1'b0, NO_OUTCOME);
            end
        end
    endtask

    // Result side. Each transfer is preceded by a random stall; once, well into the run,
    // ready stays low for a long stretch so that the block backs up and refuses commands.
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(recv_calm);
            if (!long_hold_done && items_accepted >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Every result transfer is held against the oldest outstanding outcome.
    always @(posedge clk)
    begin
        dfn_result_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transfer with no outcome outstanding");
                mismatches++;
            end
            else
            begin
                due = pending_outcomes.pop_front();
                check_field("status", due.status, result.status);
                check_field("result_index", due.result_index, result.result_index);
                check_field("blur_event", due.blur_event, result.blur_event);
                check_field("blurred_index", due.blurred_index, result.blurred_index);
                check_field("focus_event", due.focus_event, result.focus_event);
                check_field("focused_valid", due.focused_valid, result.focused_valid);
                check_field("focused_index", due.focused_index, result.focused_index);
                check_field("entry_count", due.entry_count, result.entry_count);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        rst_n <= 1'b0;

        // Directed script, in player mode. Empty table first: blur with nothing focused is
        // quietly accepted; navigate, focus and update have nothing to act on.
        add_row(make_item(CMD_BLUR, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_item(CMD_FOCUS, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_item(CMD_UPDATE, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_BAD_INDEX, 0, 0, 0, 0, 0, 0, 0));
        // Five entries, two of them at the corners of the coordinate range.
        add_row(make_item(CMD_ADD, 0, -2048, -2048, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 0, 0, 0, 0, 0, 0, 1));
        add_row(make_item(CMD_ADD, 0, 2047, 2047, 4095, 4095, 255, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 1, 0, 0, 0, 0, 0, 2));
        add_row(make_item(CMD_ADD, 0, 0, 0, 10, 10, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 2, 0, 0, 0, 0, 0, 3));
        add_row(make_item(CMD_ADD, 0, 0, -2048, 0, 4095, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 3, 0, 0, 0, 0, 0, 4));
        add_row(make_item(CMD_ADD, 0, 300, 5, 0, 0, 7, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 4, 0, 0, 0, 0, 0, 5));
        // Focus, then focus the same entry again: it is blurred and refocused.
        add_row(make_item(CMD_FOCUS, 2, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 2, 0, 0, 1, 1, 2, 5));
        add_row(make_item(CMD_FOCUS, 2, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 2, 1, 2, 1, 1, 2, 5));
        // Navigation in all four directions, including row-fenced moves with no neighbour.
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_RIGHT), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_LEFT), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_DOWN), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b0, NO_OUTCOME);
        // Update keeps the row; out-of-range update and focus change nothing.
        add_row(make_item(CMD_UPDATE, 1, -2048, 2047, 4095, 0, 9, DIR_UP), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_UPDATE, 63, 0, 0, 0, 0, 0, DIR_UP), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_FOCUS, 63, 0, 0, 0, 0, 0, DIR_UP), 1'b0, NO_OUTCOME);
        // Spare command codes with every other field set.
        add_row(make_item(CMD_SPARE_A, 63, -1, -1, 4095, 4095, 255, DIR_RIGHT), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_SPARE_B, 63, -1, -1, 4095, 4095, 255, DIR_RIGHT), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_NAV, 0, 0, 0, 0, 0, 0, DIR_RIGHT), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_BLUR, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b0, NO_OUTCOME);
        add_row(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_item(CMD_ADD, 0, 12, 34, 56, 78, 1, DIR_UP), 1'b1,
                make_outcome(STATUS_OK, 0, 0, 0, 0, 0, 0, 1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_mode(1'b0);
        foreach (script[i])
            offer_command(script[i].stim, script[i].typed, script[i].want);

        // Random phases. The mode is changed only with nothing outstanding, and each change
        // also makes the sender wait for every outcome to come back.
        while (items_accepted < ITEM_TARGET)
        begin
            settle(SETTLE_CYCLES);
            program_mode(phase_count[0]);
            run_phase($urandom_range(0, 2) != 0);
            phase_count++;
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
